### sv/gara_pkg.sv
// gara_pkg: shared types and constants of the grid atlas rectangle allocator
// used by gara_cell and grid_atlas_rect_allocator_unit, no dependencies
package gara_pkg;

  localparam int MaxRectsDefault = 64;
  localparam logic [14:0] AtlasLimit = 15'd16384;
  localparam logic [14:0] AtlasReset = 15'd4096;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_REUSE,
    MODE_FREE,
    MODE_OVL
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_GRID,
    S_SKIP,
    S_DONE
  } state_t;

  // probe that walks down the cell chain, one cell per cycle
  typedef struct packed {
    logic        valid;
    mode_t       mode;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [14:0] qw;
    logic [14:0] qh;
    logic        found;
    logic [13:0] fx;
    logic [13:0] fy;
    logic [15:0] fend;
  } tok_t;

endpackage

### sv/grid_atlas_rect_allocator_unit.sv
// grid_atlas_rect_allocator_unit: top level of the grid first-fit atlas allocator
// depends on gara_pkg and gara_cell
//
// usage
// - input channel (in_*): one request of operation, size and position, taken
//   when in_valid is high and in_stall low; stall stays high while a request
//   is being worked on, so one request is in the block at a time
// - result channel (out_*): one result per request, held in an output register
//   until taken (out_valid high, out_stall low); while the receiver stalls a
//   finished result waits in a done state and no new request is taken
// - config port (cfg_*): atlas width at byte 0, height at byte 4; the low 15 bits
//   of a write are used and values above 16384 saturate; write only while idle
// - clear and bad requests go straight to the done state; free makes one chain walk
// - allocate: one chain walk for reuse, then one chain walk per grid cell tried,
//   plus a skip state visit per grid step skipped and a grid state visit per skip
//   and per row change, so the time an allocation takes depends on atlas size and fill
// - the entries live in a chain of cells; a probe token moves one cell per cycle
// - reset clears the entry count and the control state, table contents stay
module grid_atlas_rect_allocator_unit #(
  parameter int MAX_RECTS = gara_pkg::MaxRectsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [14:0] in_req_width,
  input  logic [14:0] in_req_height,
  input  logic [13:0] in_req_x,
  input  logic [13:0] in_req_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_success,
  output logic [13:0] out_x,
  output logic [13:0] out_y,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  // config registers
  logic [14:0] atlas_w_r, atlas_h_r, cfg_v;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_v      = (cfg_pwdata[14:0] > gara_pkg::AtlasLimit) ? gara_pkg::AtlasLimit
                                                                 : cfg_pwdata[14:0];
  assign cfg_prdata = {17'd0, (cfg_paddr[2] == gara_pkg::CFG_HEIGHT) ? atlas_h_r : atlas_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= gara_pkg::AtlasReset;
      atlas_h_r <= gara_pkg::AtlasReset;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == gara_pkg::CFG_WIDTH) atlas_w_r <= cfg_v;
      else                                     atlas_h_r <= cfg_v;
    end
  end

  // control registers
  gara_pkg::state_t state_r, state_nxt;
  gara_pkg::mode_t  mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [14:0]      qw_r, qw_nxt, qh_r, qh_nxt;
  logic [13:0]      qx_r, qx_nxt, qy_r, qy_nxt;
  logic [15:0]      px_r, px_nxt, py_r, py_nxt, skip_r, skip_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [13:0]      res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic             out_valid_r;
  logic             out_success_r;
  logic [13:0]      out_x_r, out_y_r;
  logic             accept, launch, append, load_out;

  gara_pkg::tok_t tok_head;
  gara_pkg::tok_t chain [MAX_RECTS+1];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != gara_pkg::S_IDLE);
  assign load_out = (state_r == gara_pkg::S_DONE) && (!out_valid_r || !out_stall);

  // probe launched into the head of the chain
  always_comb begin
    tok_head       = '0;
    tok_head.valid = launch;
    tok_head.mode  = mode_nxt;
    tok_head.qw    = qw_nxt;
    tok_head.qh    = qh_nxt;
    if (mode_nxt == gara_pkg::MODE_OVL) begin
      tok_head.qx = px_nxt;
      tok_head.qy = py_nxt;
    end else begin
      tok_head.qx = {2'b00, qx_nxt};
      tok_head.qy = {2'b00, qy_nxt};
    end
  end

  assign chain[0] = tok_head;

  // next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    qw_nxt    = qw_r;
    qh_nxt    = qh_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    skip_nxt  = skip_r;
    res_ok_nxt = res_ok_r;
    res_x_nxt  = res_x_r;
    res_y_nxt  = res_y_r;
    launch    = 1'b0;
    append    = 1'b0;
    case (state_r)
      gara_pkg::S_IDLE: begin
        if (accept) begin
          qw_nxt = in_req_width;
          qh_nxt = in_req_height;
          qx_nxt = in_req_x;
          qy_nxt = in_req_y;
          res_ok_nxt = 1'b0;
          res_x_nxt  = '0;
          res_y_nxt  = '0;
          state_nxt  = gara_pkg::S_DONE;
          case (in_operation)
            gara_pkg::OP_ALLOC: begin
              if (in_req_width != '0 && in_req_height != '0) begin
                mode_nxt  = gara_pkg::MODE_REUSE;
                launch    = 1'b1;
                state_nxt = gara_pkg::S_WAIT;
              end
            end
            gara_pkg::OP_FREE: begin
              mode_nxt  = gara_pkg::MODE_FREE;
              launch    = 1'b1;
              state_nxt = gara_pkg::S_WAIT;
            end
            gara_pkg::OP_CLEAR: begin
              count_nxt  = '0;
              res_ok_nxt = 1'b1;
            end
            default: res_ok_nxt = 1'b0;
          endcase
        end
      end
      gara_pkg::S_WAIT: begin
        if (chain[MAX_RECTS].valid) begin
          case (mode_r)
            gara_pkg::MODE_FREE: begin
              res_ok_nxt = 1'b1;
              state_nxt  = gara_pkg::S_DONE;
            end
            gara_pkg::MODE_REUSE: begin
              if (chain[MAX_RECTS].found) begin
                res_ok_nxt = 1'b1;
                res_x_nxt  = chain[MAX_RECTS].fx;
                res_y_nxt  = chain[MAX_RECTS].fy;
                state_nxt  = gara_pkg::S_DONE;
              end else if (count_r >= CNT_W'(MAX_RECTS)) begin
                state_nxt = gara_pkg::S_DONE;
              end else begin
                px_nxt    = '0;
                py_nxt    = '0;
                state_nxt = gara_pkg::S_GRID;
              end
            end
            default: begin
              // grid cell probe came back
              if (!chain[MAX_RECTS].found) begin
                append     = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                res_ok_nxt = 1'b1;
                res_x_nxt  = px_r[13:0];
                res_y_nxt  = py_r[13:0];
                state_nxt  = gara_pkg::S_DONE;
              end else begin
                skip_nxt  = chain[MAX_RECTS].fend;
                px_nxt    = px_r + {1'b0, qw_r};
                state_nxt = gara_pkg::S_SKIP;
              end
            end
          endcase
        end
      end
      gara_pkg::S_GRID: begin
        if ((py_r + {1'b0, qh_r}) > {1'b0, atlas_h_r}) begin
          state_nxt = gara_pkg::S_DONE;
        end else if ((px_r + {1'b0, qw_r}) > {1'b0, atlas_w_r}) begin
          // next row
          px_nxt = '0;
          py_nxt = py_r + {1'b0, qh_r};
        end else begin
          mode_nxt  = gara_pkg::MODE_OVL;
          launch    = 1'b1;
          state_nxt = gara_pkg::S_WAIT;
        end
      end
      gara_pkg::S_SKIP: begin
        // every cell left of the blocking entry's right edge overlaps it
        if (px_r >= skip_r) state_nxt = gara_pkg::S_GRID;
        else                px_nxt    = px_r + {1'b0, qw_r};
      end
      gara_pkg::S_DONE: begin
        if (load_out) state_nxt = gara_pkg::S_IDLE;
      end
      default: state_nxt = gara_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gara_pkg::S_IDLE;
      count_r <= '0;
      mode_r  <= gara_pkg::MODE_REUSE;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qw_r     <= qw_nxt;
    qh_r     <= qh_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    skip_r   <= skip_nxt;
    res_ok_r <= res_ok_nxt;
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_success_r <= res_ok_r;
      out_x_r       <= res_x_r;
      out_y_r       <= res_y_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;

  // chain of entry cells
  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    gara_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .wr_en   (append && (count_r == CNT_W'(i))),
      .wr_x    (px_r[13:0]),
      .wr_y    (py_r[13:0]),
      .wr_w    (qw_r),
      .wr_h    (qh_r)
    );
  end

  // entry count never passes the table size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECTS))
    else $error("entry count above table size");

  // a probe only leaves the chain while the controller waits for it
  a_tok_wait: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_RECTS].valid |-> state_r == gara_pkg::S_WAIT)
    else $error("probe left chain outside wait state");

  // a clear request empties the table
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_operation == gara_pkg::OP_CLEAR |=> count_r == '0)
    else $error("clear did not empty table");

endmodule

### sv/gara_cell.sv
// gara_cell: one table entry of the allocator plus one stage of the probe chain
// depends on gara_pkg
module gara_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  count,
  input  gara_pkg::tok_t    tok_in,
  output gara_pkg::tok_t    tok_out,
  input  logic              wr_en,
  input  logic [13:0]       wr_x,
  input  logic [13:0]       wr_y,
  input  logic [14:0]       wr_w,
  input  logic [14:0]       wr_h
);

  logic [13:0] x_r, y_r;
  logic [14:0] w_r, h_r;
  logic        alloc_r, alloc_nxt;
  gara_pkg::tok_t tok_r, tok_nxt;
  logic        live, hit;
  logic [15:0] xend, yend;

  assign live = (CNT_W'(INDEX) < count);
  assign xend = {2'b00, x_r} + {1'b0, w_r};
  assign yend = {2'b00, y_r} + {1'b0, h_r};

  always_comb begin
    case (tok_in.mode)
      gara_pkg::MODE_REUSE: hit = !alloc_r && (w_r == tok_in.qw) && (h_r == tok_in.qh);
      gara_pkg::MODE_FREE:  hit = ({2'b00, x_r} == tok_in.qx) && ({2'b00, y_r} == tok_in.qy)
                                  && (w_r == tok_in.qw) && (h_r == tok_in.qh);
      gara_pkg::MODE_OVL:   hit = alloc_r && (tok_in.qx < xend)
                                  && ((tok_in.qx + {1'b0, tok_in.qw}) > {2'b00, x_r})
                                  && (tok_in.qy < yend)
                                  && ((tok_in.qy + {1'b0, tok_in.qh}) > {2'b00, y_r});
      default:              hit = 1'b0;
    endcase
  end

  always_comb begin
    tok_nxt   = tok_in;
    alloc_nxt = alloc_r;
    if (tok_in.valid && !tok_in.found && live && hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.fx    = x_r;
      tok_nxt.fy    = y_r;
      tok_nxt.fend  = xend;
      if (tok_in.mode == gara_pkg::MODE_REUSE) alloc_nxt = 1'b1;
      if (tok_in.mode == gara_pkg::MODE_FREE)  alloc_nxt = 1'b0;
    end
    if (wr_en) alloc_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alloc_r <= alloc_nxt;
    if (wr_en) begin
      x_r <= wr_x;
      y_r <= wr_y;
      w_r <= wr_w;
      h_r <= wr_h;
    end
  end

  assign tok_out = tok_r;

endmodule
